// ----- src/dfsl_pkg.sv -----
// Shared types, constants and command/status structs for the DDS frequency loader.
package dfsl_pkg;

	localparam int FREQ_BITS  = 28;
	localparam int FRAME_BITS = 16;
	localparam int HALF_BITS  = 14;
	localparam int WORD_BITS  = 16;
	localparam int DIV_BITS   = 16;
	localparam int CNT_BITS   = $clog2(FRAME_BITS + 1);

	localparam logic [FRAME_BITS-1:0] PREFIX_FREQ   = FRAME_BITS'(16'h4000);
	localparam logic [FRAME_BITS-1:0] CMD_RESET_B28 = FRAME_BITS'(16'h2100);
	localparam logic [FRAME_BITS-1:0] CMD_PHASE     = FRAME_BITS'(16'hC000);
	localparam logic [FRAME_BITS-1:0] CMD_RUN_B28   = FRAME_BITS'(16'h2000);
	localparam logic [DIV_BITS-1:0]   HALF_PERIOD_RST = DIV_BITS'(1000);

	// Input and result words
	typedef struct packed {
		logic [FREQ_BITS-1:0] freq_word;
		logic                 full_init;
	} in_word_t;

	typedef struct packed {
		logic [WORD_BITS-1:0] spi_word;
		logic                 frame_last;
	} out_word_t;

	// Which frame of the sequence is to be sent
	typedef enum logic [2:0] {
		FR_RESET,
		FR_LOW,
		FR_HIGH,
		FR_PHASE,
		FR_RUN
	} frame_code_t;

	// Controller to datapath
	typedef struct packed {
		logic        latch_req;
		logic        start;
		frame_code_t code;
		logic        capture;
		logic        last;
	} dp_cmd_t;

	// Datapath to controller
	typedef struct packed {
		logic frame_done;
	} dp_status_t;

	// Frame sequence: full load RESET LOW HIGH PHASE RUN, update LOW HIGH RUN
	function automatic frame_code_t frame_of(input logic full, input logic [2:0] idx);
		frame_code_t code;
		code = FR_RUN;
		if (full) begin
			case (idx)
				3'd0:    code = FR_RESET;
				3'd1:    code = FR_LOW;
				3'd2:    code = FR_HIGH;
				3'd3:    code = FR_PHASE;
				default: code = FR_RUN;
			endcase
		end else begin
			case (idx)
				3'd0:    code = FR_LOW;
				3'd1:    code = FR_HIGH;
				default: code = FR_RUN;
			endcase
		end
		return code;
	endfunction

endpackage

// ----- src/dfsl_ctrl.sv -----
// Sequencing state machine: accepts a request, steps through its frames, hands out results.
module dfsl_ctrl import dfsl_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic       full_init,
	output logic       out_valid,
	input  logic       out_ready,
	output dp_cmd_t    cmd,
	input  dp_status_t status
);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_LOAD,
		ST_SHIFT,
		ST_OUT
	} state_t;

	state_t      state_q;
	logic [2:0]  idx_q;
	logic        full_q;
	logic        out_valid_q;
	frame_code_t code;
	logic        last;

	assign code = frame_of(full_q, idx_q);
	assign last = full_q ? (idx_q == 3'd4) : (idx_q == 3'd2);

	assign in_ready  = (state_q == ST_IDLE);
	assign out_valid = out_valid_q;

	// Commands to the datapath
	always_comb begin
		cmd.latch_req = in_valid && (state_q == ST_IDLE);
		cmd.start     = (state_q == ST_LOAD);
		cmd.code      = code;
		cmd.capture   = (state_q == ST_SHIFT) && status.frame_done;
		cmd.last      = last;
	end

	// State and registered outputs
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			idx_q       <= '0;
			full_q      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (in_valid) begin
						idx_q   <= '0;
						full_q  <= full_init;
						state_q <= ST_LOAD;
					end
				end
				ST_LOAD: begin
					state_q <= ST_SHIFT;
				end
				ST_SHIFT: begin
					if (status.frame_done) begin
						out_valid_q <= 1'b1;
						state_q     <= ST_OUT;
					end
				end
				ST_OUT: begin
					if (out_ready) begin
						out_valid_q <= 1'b0;
						if (last) begin
							state_q <= ST_IDLE;
						end else begin
							idx_q   <= idx_q + 3'd1;
							state_q <= ST_LOAD;
						end
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

endmodule

// ----- src/dfsl_datapath.sv -----
// Frame builder, serial shifter with clock divider and loop-back capture, result register.
module dfsl_datapath import dfsl_pkg::*; (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cfg_we,
	input  logic [DIV_BITS-1:0] cfg_wdata,
	input  logic [FREQ_BITS-1:0] freq_word,
	input  dp_cmd_t             cmd,
	output dp_status_t          status,
	output out_word_t           out_data
);

	logic [DIV_BITS-1:0]   half_q;
	logic [FREQ_BITS-1:0]  req_q;
	logic [FRAME_BITS-1:0] shift_q;
	logic [FRAME_BITS-1:0] cap_q;
	logic [CNT_BITS-1:0]   bit_cnt_q;
	logic [DIV_BITS-1:0]   div_q;
	logic                  sclk_q;
	logic                  fsync_q;
	logic                  busy_q;
	logic                  done_q;
	out_word_t             out_q;
	logic [FRAME_BITS-1:0] frame;
	logic                  sdata;
	logic                  half_end;

	// Half-period register; zero behaves as one
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			half_q <= HALF_PERIOD_RST;
		end else if (cfg_we) begin
			half_q <= (cfg_wdata == '0) ? DIV_BITS'(1) : cfg_wdata;
		end
	end

	// Request latch
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			req_q <= '0;
		end else if (cmd.latch_req) begin
			req_q <= freq_word;
		end
	end

	// Frame selection, halves carry the frequency prefix
	always_comb begin
		case (cmd.code)
			FR_RESET: frame = CMD_RESET_B28;
			FR_LOW:   frame = PREFIX_FREQ | FRAME_BITS'(req_q[HALF_BITS-1:0]);
			FR_HIGH:  frame = PREFIX_FREQ | FRAME_BITS'(req_q[2*HALF_BITS-1:HALF_BITS]);
			FR_PHASE: frame = CMD_PHASE;
			FR_RUN:   frame = CMD_RUN_B28;
			default:  frame = CMD_RUN_B28;
		endcase
	end

	assign sdata    = shift_q[FRAME_BITS-1];
	assign half_end = (div_q == half_q - DIV_BITS'(1));

	// Serial engine: data moves while clock high, sampled on the falling edge
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			shift_q   <= '0;
			cap_q     <= '0;
			bit_cnt_q <= '0;
			div_q     <= '0;
			sclk_q    <= 1'b1;
			fsync_q   <= 1'b1;
			busy_q    <= 1'b0;
			done_q    <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (cmd.start) begin
				shift_q   <= frame;
				bit_cnt_q <= CNT_BITS'(FRAME_BITS);
				div_q     <= '0;
				sclk_q    <= 1'b1;
				fsync_q   <= 1'b0;
				busy_q    <= 1'b1;
			end else if (busy_q) begin
				if (half_end) begin
					div_q <= '0;
					if (sclk_q) begin
						// falling edge: the part takes the bit
						sclk_q    <= 1'b0;
						cap_q     <= {cap_q[FRAME_BITS-2:0], sdata};
						bit_cnt_q <= bit_cnt_q - CNT_BITS'(1);
					end else begin
						sclk_q <= 1'b1;
						if (bit_cnt_q == '0) begin
							fsync_q <= 1'b1;
							busy_q  <= 1'b0;
							done_q  <= 1'b1;
						end else begin
							shift_q <= shift_q << 1;
						end
					end
				end else begin
					div_q <= div_q + DIV_BITS'(1);
				end
			end
		end
	end

	// Result register; frame sync high marks the line idle again
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_q <= '0;
		end else if (cmd.capture) begin
			out_q.spi_word   <= WORD_BITS'(cap_q);
			out_q.frame_last <= cmd.last;
		end
	end

	assign status.frame_done = done_q && fsync_q && sclk_q;
	assign out_data = out_q;

endmodule

// ----- src/dds_frequency_spi_loader.sv -----
// Top level of the DDS frequency serial loader.
// Each accepted word (freq_word, full_init) is sent to the synthesizer as a
// sequence of 16-bit frames, MSB first with frame sync low: a full load sends
// 0x2100, low half, high half, 0xC000, 0x2000; an update sends low half, high
// half, 0x2000, each half being 14 bits of the word under the 0x4000 prefix.
// Data changes while the serial clock is high and is sampled on its falling
// edge; each frame as seen on the data line is handed out as one result word,
// frame_last marking the final one. One request is handled at a time. The serial
// half period lasts the number of system clocks written through cfg_wdata (zero
// counts as one), and the sequencer waits for each frame's result to be taken
// before the next frame is sent; the serial clock divider sets how long a request takes.
module dds_frequency_spi_loader import dfsl_pkg::*; (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cfg_we,
	input  logic [DIV_BITS-1:0] cfg_wdata,
	input  logic                in_valid,
	output logic                in_ready,
	input  in_word_t            in_data,
	output logic                out_valid,
	input  logic                out_ready,
	output out_word_t           out_data
);

	dp_cmd_t    cmd;
	dp_status_t status;

	// Sequencer
	dfsl_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.full_init (in_data.full_init),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.cmd       (cmd),
		.status    (status)
	);

	// Serial datapath
	dfsl_datapath u_datapath (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.freq_word (in_data.freq_word),
		.cmd       (cmd),
		.status    (status),
		.out_data  (out_data)
	);

endmodule
